// File: hw/rtl/ntv_pkg.sv
// Shared types, constants and character codes for the numeric text validator.
// No dependencies; every other file of the block refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package ntv_pkg;

    // Characters beyond MAX_CHARS-1 kept ones are ignored.
    localparam int MAX_CHARS = 1024;
    localparam int CNT_W     = $clog2(MAX_CHARS);
    localparam logic [CNT_W-1:0] KEEP_LIMIT = CNT_W'(MAX_CHARS - 1);

    // Exponent digits saturate at 9999, which fits in 14 bits.
    localparam int EXP_W = 14;
    localparam logic [EXP_W-1:0] EXP_SAT = EXP_W'(9999);

    // Configuration port geometry.
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;

    // Signed width that holds the exponent plus or minus the mantissa order.
    localparam int SUM_W = ((EXP_W > CNT_W) ? EXP_W : CNT_W) + 2;

    // Character codes.
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_E_LO  = 8'h65;
    localparam logic [7:0] CH_E_UP  = 8'h45;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REAL_MODE,
        CFG_FINAL_CHECK,
        CFG_MAX_DEC_EXP,
        CFG_MIN_DEC_EXP
    } cfg_index_t;

    typedef enum logic [2:0] {
        PH_START,
        PH_MANT,
        PH_EXP_START,
        PH_EXP_SIGN,
        PH_EXP_DIG,
        PH_BAD
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK,
        ST_EMPTY,
        ST_GARBAGE,
        ST_LARGE,
        ST_SMALL
    } status_t;

    localparam logic signed [CFG_W-1:0] MAX_DEC_EXP_RESET = 12'sd308;
    localparam logic signed [CFG_W-1:0] MIN_DEC_EXP_RESET = -12'sd307;

    typedef struct packed {
        logic                    real_mode;
        logic                    final_check;
        logic signed [CFG_W-1:0] max_dec_exp;
        logic signed [CFG_W-1:0] min_dec_exp;
    } cfg_t;

    typedef struct packed {
        logic [7:0] text_char;
        logic       last;
    } char_beat_t;

endpackage

`default_nettype wire

// File: hw/rtl/ntv_in_reg.sv
// Input register stage: captures one character beat and holds it until the parser takes it.
// Depends on ntv_pkg for the beat type.
`timescale 1ns / 1ps
`default_nettype none

module ntv_in_reg (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic [7:0]         text_char,
    input  wire logic               last,
    output logic                    in_stall,
    input  wire logic               advance,
    output logic                    beat_valid,
    output ntv_pkg::char_beat_t     beat
);

    logic                valid_reg;
    logic                valid_next;
    ntv_pkg::char_beat_t beat_reg;

    // The held beat blocks the input only while the parser cannot take it.
    assign in_stall   = valid_reg && !advance;
    assign valid_next = in_stall ? valid_reg : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            beat_reg.text_char <= text_char;
            beat_reg.last      <= last;
        end
    end

    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

endmodule

`default_nettype wire

// File: hw/rtl/ntv_parser.sv
// Parse state machine and range judge: updates counters and flags per character and
// forms the status of a string at its last character. Depends on ntv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ntv_parser (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ntv_pkg::cfg_t       cfg,
    input  wire ntv_pkg::char_beat_t beat,
    input  wire logic                consume,
    output ntv_pkg::status_t         status_next
);

    ntv_pkg::phase_t             phase_reg, phase_next;
    logic [ntv_pkg::CNT_W-1:0]   kept_reg, kept_next;
    logic [ntv_pkg::CNT_W-1:0]   mant_len_reg, mant_len_next;
    logic [ntv_pkg::CNT_W-1:0]   int_sig_reg, int_sig_next;
    logic [ntv_pkg::CNT_W-1:0]   frac_zeros_reg, frac_zeros_next;
    logic [ntv_pkg::EXP_W-1:0]   exp_value_reg, exp_value_next;
    logic                        point_seen_reg, point_seen_next;
    logic                        nonzero_reg, nonzero_next;
    logic                        exp_neg_reg, exp_neg_next;
    logic                        exp_dig_reg, exp_dig_next;
    logic                        sign_first_reg, sign_first_next;
    logic                        int_bad_reg, int_bad_next;

    logic [7:0]                  c;
    logic                        is_space;
    logic                        is_digit;
    logic                        is_sign;
    logic                        keep;
    logic [ntv_pkg::EXP_W+3:0]   exp_wide;

    logic signed [ntv_pkg::SUM_W-1:0] exp_term;
    logic signed [ntv_pkg::SUM_W-1:0] order_term;
    logic signed [ntv_pkg::SUM_W-1:0] dec_exp;
    logic signed [ntv_pkg::SUM_W-1:0] max_ext;
    logic signed [ntv_pkg::SUM_W-1:0] min_ext;

    assign c        = beat.text_char;
    assign is_space = (c == ntv_pkg::CH_SPACE) ||
                      ((c >= ntv_pkg::CH_TAB) && (c <= ntv_pkg::CH_CR));
    assign is_digit = (c >= ntv_pkg::CH_ZERO) && (c <= ntv_pkg::CH_NINE);
    assign is_sign  = (c == ntv_pkg::CH_MINUS) || (c == ntv_pkg::CH_PLUS);
    assign keep     = !is_space && (kept_reg < ntv_pkg::KEEP_LIMIT);

    // Next exponent value: ten times the old value plus the digit.
    assign exp_wide = (ntv_pkg::EXP_W + 4)'(exp_value_reg) * (ntv_pkg::EXP_W + 4)'(10)
                    + (ntv_pkg::EXP_W + 4)'(c - ntv_pkg::CH_ZERO);

    always_comb
    begin
        ntv_pkg::phase_t ph;
        logic            do_rest;

        phase_next      = phase_reg;
        kept_next       = kept_reg;
        mant_len_next   = mant_len_reg;
        int_sig_next    = int_sig_reg;
        frac_zeros_next = frac_zeros_reg;
        exp_value_next  = exp_value_reg;
        point_seen_next = point_seen_reg;
        nonzero_next    = nonzero_reg;
        exp_neg_next    = exp_neg_reg;
        exp_dig_next    = exp_dig_reg;
        sign_first_next = sign_first_reg;
        int_bad_next    = int_bad_reg;

        ph      = (phase_reg == ntv_pkg::PH_START) ? ntv_pkg::PH_MANT : phase_reg;
        do_rest = !((phase_reg == ntv_pkg::PH_START) && is_sign);

        if (keep)
        begin
            kept_next  = kept_reg + 1'b1;
            phase_next = ph;
            if (!do_rest)
            begin
                sign_first_next = 1'b1;
            end
            else
            begin
                if (!is_digit)
                begin
                    int_bad_next = 1'b1;
                end
                case (ph)
                    ntv_pkg::PH_MANT:
                    begin
                        if (c == ntv_pkg::CH_POINT)
                        begin
                            if (point_seen_reg)
                            begin
                                phase_next = ntv_pkg::PH_BAD;
                            end
                            else
                            begin
                                point_seen_next = 1'b1;
                                mant_len_next   = mant_len_reg + 1'b1;
                            end
                        end
                        else if (is_digit)
                        begin
                            mant_len_next = mant_len_reg + 1'b1;
                            if (!point_seen_reg)
                            begin
                                if (nonzero_reg || (c != ntv_pkg::CH_ZERO))
                                begin
                                    nonzero_next = 1'b1;
                                    int_sig_next = int_sig_reg + 1'b1;
                                end
                            end
                            else if (!nonzero_reg)
                            begin
                                if (c == ntv_pkg::CH_ZERO)
                                begin
                                    frac_zeros_next = frac_zeros_reg + 1'b1;
                                end
                                else
                                begin
                                    nonzero_next = 1'b1;
                                end
                            end
                        end
                        else if ((c == ntv_pkg::CH_E_LO) || (c == ntv_pkg::CH_E_UP))
                        begin
                            phase_next = ntv_pkg::PH_EXP_START;
                        end
                        else
                        begin
                            phase_next = ntv_pkg::PH_BAD;
                        end
                    end
                    ntv_pkg::PH_EXP_START, ntv_pkg::PH_EXP_SIGN, ntv_pkg::PH_EXP_DIG:
                    begin
                        if ((ph == ntv_pkg::PH_EXP_START) && is_sign)
                        begin
                            exp_neg_next = (c == ntv_pkg::CH_MINUS);
                            phase_next   = ntv_pkg::PH_EXP_SIGN;
                        end
                        else if (is_digit)
                        begin
                            if (exp_wide > (ntv_pkg::EXP_W + 4)'(ntv_pkg::EXP_SAT))
                            begin
                                exp_value_next = ntv_pkg::EXP_SAT;
                            end
                            else
                            begin
                                exp_value_next = exp_wide[ntv_pkg::EXP_W-1:0];
                            end
                            exp_dig_next = 1'b1;
                            phase_next   = ntv_pkg::PH_EXP_DIG;
                        end
                        else
                        begin
                            phase_next = ntv_pkg::PH_BAD;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Decimal exponent: signed exponent digits plus the order of the mantissa.
    always_comb
    begin
        exp_term   = '0;
        order_term = '0;
        if (exp_dig_next)
        begin
            exp_term = $signed({{(ntv_pkg::SUM_W - ntv_pkg::EXP_W){1'b0}}, exp_value_next});
            if (exp_neg_next)
            begin
                exp_term = -exp_term;
            end
        end
        if (nonzero_next)
        begin
            if (int_sig_next != '0)
            begin
                order_term = $signed({{(ntv_pkg::SUM_W - ntv_pkg::CNT_W){1'b0}}, int_sig_next})
                           - ntv_pkg::SUM_W'(1);
            end
            else
            begin
                order_term = -($signed({{(ntv_pkg::SUM_W - ntv_pkg::CNT_W){1'b0}},
                                        frac_zeros_next}) + ntv_pkg::SUM_W'(1));
            end
        end
        dec_exp = exp_term + order_term;
    end

    assign max_ext = $signed({{(ntv_pkg::SUM_W - ntv_pkg::CFG_W){cfg.max_dec_exp[ntv_pkg::CFG_W-1]}},
                              cfg.max_dec_exp});
    assign min_ext = $signed({{(ntv_pkg::SUM_W - ntv_pkg::CFG_W){cfg.min_dec_exp[ntv_pkg::CFG_W-1]}},
                              cfg.min_dec_exp});

    always_comb
    begin
        if (kept_next == {{(ntv_pkg::CNT_W - 1){1'b0}}, sign_first_next})
        begin
            status_next = cfg.final_check ? ntv_pkg::ST_EMPTY : ntv_pkg::ST_OK;
        end
        else if (!cfg.real_mode)
        begin
            status_next = int_bad_next ? ntv_pkg::ST_GARBAGE : ntv_pkg::ST_OK;
        end
        else if (phase_next == ntv_pkg::PH_BAD)
        begin
            status_next = ntv_pkg::ST_GARBAGE;
        end
        else if ((mant_len_next == '0) && cfg.final_check)
        begin
            status_next = ntv_pkg::ST_GARBAGE;
        end
        else if ((mant_len_next == ntv_pkg::CNT_W'(1)) && point_seen_next)
        begin
            // A lone point passes a tentative check only when nothing follows it.
            if (cfg.final_check || (phase_next != ntv_pkg::PH_MANT))
            begin
                status_next = ntv_pkg::ST_GARBAGE;
            end
            else
            begin
                status_next = ntv_pkg::ST_OK;
            end
        end
        else if (((phase_next == ntv_pkg::PH_EXP_START) ||
                  (phase_next == ntv_pkg::PH_EXP_SIGN)) && cfg.final_check)
        begin
            status_next = ntv_pkg::ST_GARBAGE;
        end
        else if (dec_exp > max_ext)
        begin
            status_next = ntv_pkg::ST_LARGE;
        end
        else if (dec_exp < min_ext)
        begin
            status_next = ntv_pkg::ST_SMALL;
        end
        else
        begin
            status_next = ntv_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= ntv_pkg::PH_START;
            kept_reg       <= '0;
            mant_len_reg   <= '0;
            int_sig_reg    <= '0;
            frac_zeros_reg <= '0;
            exp_value_reg  <= '0;
            point_seen_reg <= 1'b0;
            nonzero_reg    <= 1'b0;
            exp_neg_reg    <= 1'b0;
            exp_dig_reg    <= 1'b0;
            sign_first_reg <= 1'b0;
            int_bad_reg    <= 1'b0;
        end
        else if (consume)
        begin
            if (beat.last)
            begin
                phase_reg      <= ntv_pkg::PH_START;
                kept_reg       <= '0;
                mant_len_reg   <= '0;
                int_sig_reg    <= '0;
                frac_zeros_reg <= '0;
                exp_value_reg  <= '0;
                point_seen_reg <= 1'b0;
                nonzero_reg    <= 1'b0;
                exp_neg_reg    <= 1'b0;
                exp_dig_reg    <= 1'b0;
                sign_first_reg <= 1'b0;
                int_bad_reg    <= 1'b0;
            end
            else
            begin
                phase_reg      <= phase_next;
                kept_reg       <= kept_next;
                mant_len_reg   <= mant_len_next;
                int_sig_reg    <= int_sig_next;
                frac_zeros_reg <= frac_zeros_next;
                exp_value_reg  <= exp_value_next;
                point_seen_reg <= point_seen_next;
                nonzero_reg    <= nonzero_next;
                exp_neg_reg    <= exp_neg_next;
                exp_dig_reg    <= exp_dig_next;
                sign_first_reg <= sign_first_next;
                int_bad_reg    <= int_bad_next;
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/ntv_out_reg.sv
// Result register: holds one status beat until the downstream side takes it.
// Depends on ntv_pkg for the status type.
`timescale 1ns / 1ps
`default_nettype none

module ntv_out_reg (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire ntv_pkg::status_t status_in,
    output logic                  free,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic [2:0]            status
);

    logic             valid_reg;
    logic             valid_next;
    ntv_pkg::status_t status_reg;

    // The register can take a new beat when empty or when its beat leaves this cycle.
    assign free = !valid_reg || !out_stall;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg <= status_in;
        end
    end

    assign out_valid = valid_reg;
    assign status    = status_reg;

endmodule

`default_nettype wire

// File: hw/rtl/numeric_text_validator_core.sv
// Top level of the numeric text validator: configuration registers, input stage,
// parser and result register. Depends on ntv_pkg, ntv_in_reg, ntv_parser and ntv_out_reg.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one character beat per clock cycle and checks the text as an
// integer or a real literal. Each accepted beat is held in the input register while
// the parser folds it into the parse state. The status of the beat that carries last
// is loaded into the result register as that beat leaves the input register, and
// out_valid rises with that load. While out_stall is low a beat is taken in every
// cycle. When a last character reaches the input register while the previous
// status still sits untaken in the result register, it waits there and in_stall
// stays high until that status is taken. Configuration registers are written through
// cfg_wr_en, cfg_index and cfg_data and should be changed only while no string is
// in flight.
module numeric_text_validator_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [ntv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ntv_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [7:0]                    text_char,
    input  wire logic                          last,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [2:0]                         status
);

    ntv_pkg::cfg_t       cfg_reg;
    ntv_pkg::char_beat_t beat;
    logic                beat_valid;
    logic                out_free;
    logic                advance;
    ntv_pkg::status_t    status_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.real_mode   <= 1'b1;
            cfg_reg.final_check <= 1'b1;
            cfg_reg.max_dec_exp <= ntv_pkg::MAX_DEC_EXP_RESET;
            cfg_reg.min_dec_exp <= ntv_pkg::MIN_DEC_EXP_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (ntv_pkg::cfg_index_t'(cfg_index))
                ntv_pkg::CFG_REAL_MODE:   cfg_reg.real_mode   <= cfg_data[0];
                ntv_pkg::CFG_FINAL_CHECK: cfg_reg.final_check <= cfg_data[0];
                ntv_pkg::CFG_MAX_DEC_EXP: cfg_reg.max_dec_exp <= $signed(cfg_data);
                ntv_pkg::CFG_MIN_DEC_EXP: cfg_reg.min_dec_exp <= $signed(cfg_data);
                default:
                begin
                end
            endcase
        end
    end

    // A held beat moves on unless it ends a string and the result slot is busy.
    assign advance = beat_valid && (!beat.last || out_free);

    ntv_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .text_char  (text_char),
        .last       (last),
        .in_stall   (in_stall),
        .advance    (advance),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    ntv_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .beat        (beat),
        .consume     (advance),
        .status_next (status_next)
    );

    ntv_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && beat.last),
        .status_in (status_next),
        .free      (out_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status)
    );

endmodule

`default_nettype wire

// File: hw/rtl/ntv_checker.sv
// Port-level checker for the numeric text validator and its bind to the top level.
// Depends on ntv_pkg and numeric_text_validator_core.
`timescale 1ns / 1ps
`default_nettype none

module ntv_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_stall,
    input  wire logic       out_valid,
    input  wire logic       out_stall,
    input  wire logic [2:0] status
);

    // A stalled result beat stays in place with the same status.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status))
        else $error("result beat changed while stalled");

    // A result beat leaves only when it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> !$past(out_stall))
        else $error("result beat dropped without being taken");

    // The input is held back only behind an untaken result.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while the result side was free");

    // Every status is one of the five defined codes.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= 3'(ntv_pkg::ST_SMALL))
        else $error("status code out of range");

endmodule

bind numeric_text_validator_core ntv_checker u_ntv_checker (.*);

`default_nettype wire
